[rtl/ostset_pkg.sv]
package ostset_pkg;

   // Sizing of the timer bank
   localparam int NUM_TIMERS = 16;
   localparam int EVENT_W    = 8;
   localparam int TIME_W     = 32;

   // Fixed widths of the request and response fields
   localparam int OP_W       = 2;
   localparam int ID_W       = 4;
   localparam int CODE_W     = 8;
   localparam int DELAY_W    = 31;
   localparam int REQ_BITS   = OP_W + ID_W + CODE_W + DELAY_W;
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = ID_W + CODE_W;
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8;

   // Slot number and scan counter widths
   localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W      = SLOT_W;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   // Candidate handed down the chain: best due slot seen so far
   typedef struct packed {
      logic               valid;
      logic [TIME_W-1:0]  age;
      logic [SLOT_W-1:0]  slot;
      logic [EVENT_W-1:0] event_code;
   } cand_type;

   // Per-slot update from the sequencer
   typedef struct packed {
      logic               arm;
      logic               disarm;
      logic [TIME_W-1:0]  deadline;
      logic [EVENT_W-1:0] event_code;
   } cmd_type;

endpackage

[rtl/ostset_cell.sv]
module ostset_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ostset_pkg::SLOT_W-1:0] slot_idx,
   input  logic [ostset_pkg::TIME_W-1:0] now,
   input  ostset_pkg::cmd_type        cmd,
   input  ostset_pkg::cand_type       cand_i,
   output ostset_pkg::cand_type       cand_o,
   output logic                       armed_o
);
   import ostset_pkg::*;

   logic               armed_ff, armed_in;
   logic [TIME_W-1:0]  deadline_ff;
   logic [EVENT_W-1:0] event_ff;
   cand_type           cand_ff, cand_in;
   logic [TIME_W-1:0]  age;
   logic               due;
   logic               take;

   // Slot state: arm wins over disarm, never both in one cycle
   always_comb begin
      armed_in = armed_ff;
      if (cmd.disarm) begin
         armed_in = 1'b0;
      end
      if (cmd.arm) begin
         armed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
      end else begin
         armed_ff <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.arm) begin
         deadline_ff <= cmd.deadline;
         event_ff    <= cmd.event_code;
      end
   end

   // Wrap-safe age; strictly older beats the upstream (lower) slot
   assign age  = now - deadline_ff;
   assign due  = armed_ff && !age[TIME_W-1];
   assign take = due && (!cand_i.valid || (age > cand_i.age));

   always_comb begin
      cand_in = cand_i;
      if (take) begin
         cand_in.valid      = 1'b1;
         cand_in.age        = age;
         cand_in.slot       = slot_idx;
         cand_in.event_code = event_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
      end else begin
         cand_ff <= cand_in;
      end
   end

   assign cand_o  = cand_ff;
   assign armed_o = armed_ff;

endmodule

[rtl/one_shot_timer_set_core.sv]
// Channel | Dir | Ports                          | Contents
// req     | in  | req_tvalid/tready/tdata[47:0]  | op, timer_id, event_code, delay_ticks
// rsp     | out | rsp_tvalid/tready/tdata[15:0]  | fired_slot, fired_event; tlast = last
//
// Start, stop and unused opcodes are handled in the idle state.
// A tick runs one search per expiry and a final one that finds none: each search
// walks the candidate down the registered row of slot cells, one cell a cycle.
// One fired result is held back so that the final one can carry tlast.
// Synchronous active-high reset clears the time counter, all armed flags and the chain.
// A stalled rsp holds the search; requests are taken only when idle.
module one_shot_timer_set_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [1:0] op, [5:2] timer_id, [13:6] event_code, [44:14] delay_ticks, rest zero
   input  logic [ostset_pkg::REQ_W-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [3:0] fired_slot, [11:4] fired_event, rest zero
   output logic [ostset_pkg::RSP_W-1:0] rsp_tdata,
   output logic                         rsp_tlast
);
   import ostset_pkg::*;

   // Request fields
   logic [OP_W-1:0]    req_op;
   logic [ID_W-1:0]    req_id;
   logic [CODE_W-1:0]  req_code;
   logic [DELAY_W-1:0] req_delay;
   logic               req_fire;

   assign req_op    = req_tdata[OP_W-1:0];
   assign req_id    = req_tdata[OP_W +: ID_W];
   assign req_code  = req_tdata[OP_W+ID_W +: CODE_W];
   assign req_delay = req_tdata[OP_W+ID_W+CODE_W +: DELAY_W];
   assign req_fire  = req_tvalid && req_tready;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic               hold_valid_ff, hold_valid_in;
   logic [SLOT_W-1:0]  hold_slot_ff;
   logic [EVENT_W-1:0] hold_event_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_slot_ff;
   logic [CODE_W-1:0]  rsp_event_ff;
   logic               rsp_last_ff;
   logic               commit;
   logic               push;
   logic               push_last;
   logic               out_free;
   logic               do_start;
   logic               do_stop;
   logic [TIME_W-1:0]  new_deadline;

   cand_type                 chain [NUM_TIMERS];
   cand_type                 winner;
   logic [NUM_TIMERS-1:0]    armed;

   assign winner       = chain[NUM_TIMERS-1];
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign do_start     = req_fire && (req_op == OP_START);
   assign do_stop      = req_fire && (req_op == OP_STOP);
   assign new_deadline = now_ff + TIME_W'(req_delay);

   // Row of slot cells
   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      cmd_type  cmd;
      cand_type cand_up;
      logic     hit;

      assign hit = (int'(req_id) == i);
      assign cmd.arm        = do_start && hit;
      assign cmd.disarm     = (do_stop && hit) ||
                              (commit && (winner.slot == SLOT_W'(i)));
      assign cmd.deadline   = new_deadline;
      assign cmd.event_code = EVENT_W'(req_code);

      if (i == 0) begin : g_head
         assign cand_up = '0;
      end else begin : g_link
         assign cand_up = chain[i-1];
      end

      ostset_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .slot_idx (SLOT_W'(i)),
         .now      (now_ff),
         .cmd      (cmd),
         .cand_i   (cand_up),
         .cand_o   (chain[i]),
         .armed_o  (armed[i])
      );
   end

   // Sequencer: next state and controls
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      now_in     = now_ff;
      req_tready = 1'b0;
      commit     = 1'b0;
      push       = 1'b0;
      push_last  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire && (req_op == OP_TICK)) begin
               now_in   = now_ff + TIME_W'(1);
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(NUM_TIMERS - 1)) begin
               state_in = ST_DECIDE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DECIDE: begin
            if (winner.valid) begin
               if (!hold_valid_ff || out_free) begin
                  commit   = 1'b1;
                  push     = hold_valid_ff;
                  cnt_in   = '0;
                  state_in = ST_SCAN;
               end
            end else if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         now_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         now_ff   <= now_in;
      end
   end

   // Held result, released once the next search shows whether it is the last
   assign hold_valid_in = commit ? 1'b1 : (push ? 1'b0 : hold_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         hold_slot_ff  <= winner.slot;
         hold_event_ff <= winner.event_code;
      end
   end

   // Response register
   assign rsp_valid_in = push ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_slot_ff  <= ID_W'(hold_slot_ff);
         rsp_event_ff <= CODE_W'(hold_event_ff);
         rsp_last_ff  <= push_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_event_ff, rsp_slot_ff});
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !hold_valid_ff)
      else $error("request taken while a fired result is still held");

   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(hold_valid_ff))
      else $error("response raised without a held result");

   a_arm_only_start: assert property (@(posedge clock) disable iff (reset)
      ($countones(armed) > $past($countones(armed))) |-> $past(do_start))
      else $error("slot armed without a start request");

   a_fire_disarms: assert property (@(posedge clock) disable iff (reset)
      commit |=> !armed[$past(winner.slot)])
      else $error("fired slot still armed");

endmodule
